@@ rtl/ssbk_pkg.sv @@
// Shared types, constants and microcode table for the selection sort block.
// No dependencies; every other file of the block except ssbk_ram imports this package.
package ssbk_pkg;

   localparam int SSBK_MAX_RECORDS = 16;

   localparam int TAG_W   = 6;
   localparam int WEEKS_W = 10;
   localparam int PRICE_W = 24;
   localparam int KEY_W   = PRICE_W;   // wider of the two keys

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [WEEKS_W-1:0] weeks;
      logic [PRICE_W-1:0] price;
   } rec_type;

   // Microcode address
   localparam int UPC_W = 3;
   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UPC_LOAD  = 3'd0;
   localparam upc_type UPC_PASS  = 3'd1;
   localparam upc_type UPC_FRONT = 3'd2;
   localparam upc_type UPC_SCAN  = 3'd3;
   localparam upc_type UPC_EMIT  = 3'd4;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_LAST_IN,     // transfer of the record that closes the set
      COND_SCAN_END,    // scan pointer reached the record count
      COND_SET_DONE,    // final sorted record goes into the output register this cycle
      COND_OUT_BUSY     // output register still holds an untaken result
   } cond_type;

   typedef struct packed {
      logic     accept;      // take input records, write them to the store
      logic     rd_left;     // read front slot, scan pointer to front + 1
      logic     take_front;  // front record becomes current minimum
      logic     rd_scan;     // read slot at scan pointer, advance pointer
      logic     compare;     // compare read record against current minimum
      logic     emit;        // send minimum out, write front record back
      cond_type jmp_cond;
      upc_type  jmp_addr;
      cond_type hold_cond;
      upc_type  next_addr;
   } ctl_word_type;

   typedef struct packed {
      logic last_in;
      logic scan_end;
      logic set_done;
      logic out_busy;
   } seq_status_type;

   // Control store. Jump has priority over hold; otherwise go to next_addr.
   function automatic ctl_word_type ucode_word(upc_type addr);
      ctl_word_type w;
      w = '0;
      w.jmp_cond  = COND_ALWAYS;
      w.jmp_addr  = UPC_LOAD;
      w.hold_cond = COND_NEVER;
      w.next_addr = UPC_LOAD;
      unique case (addr)
         UPC_LOAD: begin
            w.accept    = 1'b1;
            w.jmp_cond  = COND_LAST_IN;
            w.jmp_addr  = UPC_PASS;
            w.hold_cond = COND_ALWAYS;
         end
         UPC_PASS: begin
            w.rd_left   = 1'b1;
            w.jmp_cond  = COND_NEVER;
            w.next_addr = UPC_FRONT;
         end
         UPC_FRONT: begin
            w.take_front = 1'b1;
            w.rd_scan    = 1'b1;
            w.jmp_cond   = COND_SCAN_END;
            w.jmp_addr   = UPC_EMIT;
            w.next_addr  = UPC_SCAN;
         end
         UPC_SCAN: begin
            w.compare   = 1'b1;
            w.rd_scan   = 1'b1;
            w.jmp_cond  = COND_SCAN_END;
            w.jmp_addr  = UPC_EMIT;
            w.hold_cond = COND_ALWAYS;
         end
         UPC_EMIT: begin
            w.emit      = 1'b1;
            w.jmp_cond  = COND_SET_DONE;
            w.jmp_addr  = UPC_LOAD;
            w.hold_cond = COND_OUT_BUSY;
            w.next_addr = UPC_PASS;
         end
         default: begin
            w.jmp_cond = COND_ALWAYS;
            w.jmp_addr = UPC_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/ssbk_req_if.sv @@
// Input channel: one record per transfer, valid/ready handshake.
// Depends on ssbk_pkg for field widths.
interface ssbk_req_if import ssbk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   record_tag;
   logic [WEEKS_W-1:0] weeks_on_lot;
   logic [PRICE_W-1:0] unit_price;
   logic               last_record;

   modport source (output valid, record_tag, weeks_on_lot, unit_price, last_record,
                   input ready);
   modport sink   (input valid, record_tag, weeks_on_lot, unit_price, last_record,
                   output ready);
endinterface

@@ rtl/ssbk_rsp_if.sv @@
// Result channel: one sorted record per transfer, valid/ready handshake.
// Depends on ssbk_pkg for field widths.
interface ssbk_rsp_if import ssbk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   sorted_tag;
   logic [WEEKS_W-1:0] sorted_weeks;
   logic [PRICE_W-1:0] sorted_price;
   logic               end_of_set;
   logic               capacity_exceeded;

   modport source (output valid, sorted_tag, sorted_weeks, sorted_price, end_of_set,
                   capacity_exceeded, input ready);
   modport sink   (input valid, sorted_tag, sorted_weeks, sorted_price, end_of_set,
                   capacity_exceeded, output ready);
endinterface

@@ rtl/selection_sort_by_key.sv @@
// Top level of the record sorter: store, selection sort datapath, output register.
// Depends on ssbk_pkg, ssbk_req_if, ssbk_rsp_if, ssbk_ram and ssbk_seq.
//
//   channel   dir   handshake          per transfer
//   req_chan  in    valid/ready        one record (tag, weeks, price, last mark)
//   rsp_chan  out   valid/ready        one sorted record, end and overflow flags
//   csr_*     in    csr_wr_en strobe   sort_by_weeks (1 weeks, 0 price)
//
// Loading takes one record per cycle. A set of n records then sorts and
// drains one output position at a time: each position costs a front read,
// a scan of the unsorted tail at one compare per cycle through the single
// RAM read port, and an emit. Synchronous active-high reset clears control
// state only; the record store has no reset and needs no clearing pass. A
// stalled result holds the sequencer in its emit step; loading of the next
// set may overlap with the last result of a set still waiting to be taken.
module selection_sort_by_key import ssbk_pkg::*; #(
   parameter int MAX_RECORDS = SSBK_MAX_RECORDS
) (
   input  logic   clock,
   input  logic   reset,
   ssbk_req_if.sink   req_chan,
   ssbk_rsp_if.source rsp_chan,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_RECORDS);
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   // sequencer interface
   ctl_word_type   word;
   seq_status_type status;

   // control registers
   logic             sort_by_weeks_ff, sort_by_weeks_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;        // records stored in this set
   logic             drop_ff, drop_in;      // a record of this set was lost
   logic [IDX_W-1:0] left_ff, left_in;      // output position being filled
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [CNT_W-1:0] scan_ff, scan_in;      // next slot to read in the tail
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;  // slot whose data the RAM returns
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   rec_type          best_rec_ff, best_rec_in;
   rec_type          front_rec_ff, front_rec_in;
   rec_type          rsp_rec_ff, rsp_rec_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             rsp_cap_ff, rsp_cap_in;

   // store ports
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   rec_type          ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   rec_type          ram_rd_data;

   logic req_xfer, store_full, scan_end, left_last, out_busy, emit_go, take_new;
   logic [KEY_W-1:0] key_rd, key_best;

   function automatic logic [KEY_W-1:0] key_of(rec_type r, logic by_weeks);
      return by_weeks ? KEY_W'(r.weeks) : r.price;
   endfunction

   ssbk_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .word   (word)
   );

   ssbk_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshakes and status
   assign req_chan.ready = word.accept;
   assign req_xfer       = req_chan.valid && word.accept;
   assign store_full     = (cnt_ff == CNT_W'(MAX_RECORDS));
   assign scan_end       = (scan_ff == cnt_ff);
   assign left_last      = ((CNT_W'(left_ff) + CNT_W'(1)) == cnt_ff);
   assign out_busy       = rsp_valid_ff && !rsp_chan.ready;
   assign emit_go        = word.emit && !out_busy;

   assign status.last_in  = req_xfer && req_chan.last_record;
   assign status.scan_end = scan_end;
   assign status.set_done = emit_go && left_last;
   assign status.out_busy = out_busy;

   // first strict minimum wins: a later equal key never displaces it
   assign key_rd   = key_of(ram_rd_data, sort_by_weeks_ff);
   assign key_best = key_of(best_rec_ff, sort_by_weeks_ff);
   assign take_new = word.compare && (key_rd < key_best);

   // store write: incoming record while loading, or the displaced front
   // record going to the slot the minimum came from while emitting
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff[IDX_W-1:0];
      ram_wr_data = '{tag:   req_chan.record_tag,
                      weeks: req_chan.weeks_on_lot,
                      price: req_chan.unit_price};
      if (req_xfer && !store_full) begin
         ram_wr_en = 1'b1;
      end else if (emit_go) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = best_idx_ff;
         ram_wr_data = front_rec_ff;
      end
   end

   assign ram_rd_addr = word.rd_left ? left_ff : scan_ff[IDX_W-1:0];

   // control next state
   always_comb begin
      sort_by_weeks_in = csr_wr_en ? csr_wr_data : sort_by_weeks_ff;
      cnt_in           = cnt_ff;
      drop_in          = drop_ff;
      left_in          = left_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;

      if (req_xfer) begin
         if (store_full) begin
            drop_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      if (emit_go) begin
         rsp_valid_in = 1'b1;
         if (left_last) begin
            cnt_in  = '0;
            drop_in = 1'b0;
            left_in = '0;
         end else begin
            left_in = left_ff + IDX_W'(1);
         end
      end
   end

   // datapath next state
   always_comb begin
      scan_in      = scan_ff;
      rd_idx_in    = rd_idx_ff;
      best_idx_in  = best_idx_ff;
      best_rec_in  = best_rec_ff;
      front_rec_in = front_rec_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_cap_in   = rsp_cap_ff;

      if (word.rd_left) begin
         scan_in = CNT_W'(left_ff) + CNT_W'(1);
      end

      if (word.take_front) begin
         best_rec_in  = ram_rd_data;
         front_rec_in = ram_rd_data;
         best_idx_in  = left_ff;
      end

      if (take_new) begin
         best_rec_in = ram_rd_data;
         best_idx_in = rd_idx_ff;
      end

      if (word.rd_scan && !scan_end) begin
         rd_idx_in = scan_ff[IDX_W-1:0];
         scan_in   = scan_ff + CNT_W'(1);
      end

      if (emit_go) begin
         rsp_rec_in = best_rec_ff;
         rsp_end_in = left_last;
         rsp_cap_in = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_by_weeks_ff <= 1'b0;
         cnt_ff           <= '0;
         drop_ff          <= 1'b0;
         left_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         sort_by_weeks_ff <= sort_by_weeks_in;
         cnt_ff           <= cnt_in;
         drop_ff          <= drop_in;
         left_ff          <= left_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_rec_ff  <= best_rec_in;
      front_rec_ff <= front_rec_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_cap_ff   <= rsp_cap_in;
   end

   // result channel
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.sorted_tag        = rsp_rec_ff.tag;
   assign rsp_chan.sorted_weeks      = rsp_rec_ff.weeks;
   assign rsp_chan.sorted_price      = rsp_rec_ff.price;
   assign rsp_chan.end_of_set        = rsp_end_ff;
   assign rsp_chan.capacity_exceeded = rsp_cap_ff;

   // sorting only ever runs on a non-empty set
   a_sort_nonempty: assert property (@(posedge clock) disable iff (reset)
      !word.accept |-> (cnt_ff != '0))
      else $error("sort step with empty store");

   // scan pointer stays inside the stored records while comparing
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      word.compare |-> (scan_ff <= cnt_ff))
      else $error("scan pointer beyond record count");

   // the minimum always comes from the unsorted tail
   a_best_in_tail: assert property (@(posedge clock) disable iff (reset)
      emit_go |-> (best_idx_ff >= left_ff))
      else $error("minimum taken from sorted region");

   // records are dropped only once the store is full
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> store_full)
      else $error("drop flag set with room in store");

endmodule

@@ rtl/ssbk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssbk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/ssbk_seq.sv @@
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on ssbk_pkg (control word, status and condition types, ucode_word).
module ssbk_seq import ssbk_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ctl_word_type   word
);

   upc_type upc_ff, upc_in;

   function automatic logic cond_hit(cond_type c, seq_status_type s);
      logic hit;
      unique case (c)
         COND_NEVER:    hit = 1'b0;
         COND_ALWAYS:   hit = 1'b1;
         COND_LAST_IN:  hit = s.last_in;
         COND_SCAN_END: hit = s.scan_end;
         COND_SET_DONE: hit = s.set_done;
         COND_OUT_BUSY: hit = s.out_busy;
         default:       hit = 1'b0;
      endcase
      return hit;
   endfunction

   assign word = ucode_word(upc_ff);

   always_comb begin
      priority if (cond_hit(word.jmp_cond, status)) begin
         upc_in = word.jmp_addr;
      end else if (cond_hit(word.hold_cond, status)) begin
         upc_in = upc_ff;
      end else begin
         upc_in = word.next_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_LOAD;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule
